// ----- rtl/core/js2d_pkg.sv -----
// ----------------------------------------------------------------------------
// js2d_pkg
// Shared constants for the 2-D Jacobi stencil stream: configuration register
// indexes, field widths and the depth of the result queue.
// ----------------------------------------------------------------------------
package js2d_pkg;

    localparam int CFG_BITS       = 12;
    localparam int CFG_INDEX_BITS = 1;
    localparam int COORD_BITS     = 11;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [CFG_BITS-1:0] DIM_RESET = 12'd2048;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = 2;

    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

endpackage

// ----- rtl/core/js2d_line_mem.sv -----
// ----------------------------------------------------------------------------
// js2d_line_mem
// Line store: one write port, two registered read ports, with write-to-read
// forwarding when a read hits the address written at the same edge.
// ----------------------------------------------------------------------------
module js2d_line_mem #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
            r_rd_a <= i_wr_data;
        end else begin
            r_rd_a <= r_mem[i_rd_addr_a];
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
            r_rd_b <= i_wr_data;
        end else begin
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- rtl/core/js2d_out_queue.sv -----
// ----------------------------------------------------------------------------
// js2d_out_queue
// Small result queue: takes up to two words per cycle, hands out one word
// per cycle under valid/stall.
// ----------------------------------------------------------------------------
module js2d_out_queue #(
    parameter int WIDTH = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  js2d_pkg::t_push      i_push,
    input  logic [WIDTH-1:0]     i_data0,
    input  logic [WIDTH-1:0]     i_data1,
    output logic                 o_room,
    output logic                 o_valid,
    output logic [WIDTH-1:0]     o_data,
    input  logic                 i_stall
);
    import js2d_pkg::*;

    logic [WIDTH-1:0]        r_slot [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]   r_wr_ptr;
    logic [Q_PTR_BITS-1:0]   r_rd_ptr;
    logic [Q_PTR_BITS:0]     r_count;
    logic [Q_PTR_BITS:0]     n_count;
    logic [Q_PTR_BITS-1:0]   n_wr_ptr;
    logic [Q_PTR_BITS-1:0]   wr_ptr1;
    logic                    pop;

    always_comb begin
        pop      = (r_count != '0) && !i_stall;
        wr_ptr1  = r_wr_ptr + 1'b1;
        n_wr_ptr = r_wr_ptr + Q_PTR_BITS'({1'b0, i_push.push0})
                            + Q_PTR_BITS'({1'b0, i_push.push1});
        n_count  = r_count + (Q_PTR_BITS + 1)'({1'b0, i_push.push0})
                           + (Q_PTR_BITS + 1)'({1'b0, i_push.push1})
                           - (Q_PTR_BITS + 1)'({1'b0, pop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_slot[r_wr_ptr] <= i_data0;
        end
        if (i_push.push1) begin
            r_slot[wr_ptr1] <= i_data1;
        end
    end

    assign o_room  = (r_count <= (Q_PTR_BITS + 1)'(Q_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

endmodule

// ----- rtl/core/jacobi_stencil_2d_stream.sv -----
// ----------------------------------------------------------------------------
// jacobi_stencil_2d_stream
// One Jacobi sweep of a raster-order grid with a 5-point stencil.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one sample word per cycle in
// raster order. Output channel: o_out_valid / i_out_stall carry result words
// with their row, column, last-of-item and frame-done flags.
// The input at row y emits the cell of row y-1; on the last row it also emits
// its own cell, so with two or more rows, last-row inputs produce two words.
// Each result word is written into the result queue as its input is taken.
// Throughput: one input per cycle while the result queue has room, set by the
// single line-store write port and the one-word-per-cycle output; on the last
// row, where each input yields two words, the output port holds the input back.
// Grid size is written through i_cfg_we / i_cfg_index / i_cfg_data while the
// block is idle (a user rule, unenforced); a write restarts the frame at row
// 0, column 0. Reset clears the position, window and result queue; line stores
// are not cleared and need no clearing pass. Stalled results wait in a
// four-word queue; the input stalls once fewer than two entries are free.
// ----------------------------------------------------------------------------
module jacobi_stencil_2d_stream #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_HEIGHT  = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [js2d_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [js2d_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [SAMPLE_BITS-1:0]            o_result,
    output logic [js2d_pkg::COORD_BITS-1:0]   o_out_row,
    output logic [js2d_pkg::COORD_BITS-1:0]   o_out_col,
    output logic                              o_last_of_item,
    output logic                              o_frame_done
);
    import js2d_pkg::*;

    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int SB        = SAMPLE_BITS;
    localparam int WORD_BITS = SB + 2 * COORD_BITS + 2;

    function automatic logic [31:0] dim_m1(logic [CFG_BITS-1:0] v, int unsigned maxv);
        logic [31:0] r;
        if (v == '0) begin
            r = '0;
        end else if (32'(v) > maxv) begin
            r = 32'(maxv - 1);
        end else begin
            r = 32'(v) - 32'd1;
        end
        return r;
    endfunction

    logic [XW-1:0]        r_w_m1;
    logic [YW-1:0]        r_h_m1;
    logic [XW-1:0]        r_x;
    logic [YW-1:0]        r_y;
    logic [SB-1:0]        r_left;
    logic [XW-1:0]        n_x;
    logic [YW-1:0]        n_y;
    logic [SB-1:0]        n_left;

    logic                 accept;
    logic                 room;
    logic                 last_col;
    logic                 last_row;
    logic [2*SB-1:0]      rd_a;
    logic [2*SB-1:0]      rd_b;
    logic [SB-1:0]        center;
    logic [SB-1:0]        up;
    logic [SB-1:0]        right;
    logic [SB+1:0]        sum;
    logic [SB-1:0]        upd;
    logic [XW-1:0]        rd_addr_b;
    logic [WORD_BITS-1:0] word_up;
    logic [WORD_BITS-1:0] word_own;
    logic [WORD_BITS-1:0] data0;
    logic [WORD_BITS-1:0] q_data;
    t_push                push;

    assign accept     = i_in_valid && room;
    assign o_in_stall = !room;

    always_comb begin
        center   = rd_a[SB-1:0];
        up       = rd_a[2*SB-1:SB];
        last_col = (r_x == r_w_m1);
        last_row = (r_y == r_h_m1);
        right    = last_col ? '0 : rd_b[SB-1:0];
        sum      = {2'b00, up} + {2'b00, i_sample} + {2'b00, r_left} + {2'b00, right};
        if ((r_y == YW'(1)) || (r_x == '0) || last_col) begin
            upd = center;
        end else begin
            upd = sum[SB+1:2];
        end
        word_up  = {upd, COORD_BITS'(r_y - 1'b1), COORD_BITS'(r_x), !last_row, 1'b0};
        word_own = {i_sample, COORD_BITS'(r_y), COORD_BITS'(r_x), 1'b1, last_col};
        data0    = (r_y != '0) ? word_up : word_own;
        push.push0 = accept && ((r_y != '0) || last_row);
        push.push1 = accept && (r_y != '0) && last_row;

        n_x    = r_x;
        n_y    = r_y;
        n_left = r_left;
        if (i_cfg_we) begin
            n_x    = '0;
            n_y    = '0;
            n_left = '0;
        end else if (accept) begin
            if (last_col) begin
                n_x    = '0;
                n_y    = last_row ? '0 : r_y + 1'b1;
                n_left = '0;
            end else begin
                n_x    = r_x + 1'b1;
                n_left = center;
            end
        end
        rd_addr_b = n_x + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1 <= XW'(dim_m1(DIM_RESET, MAX_WIDTH));
            r_h_m1 <= YW'(dim_m1(DIM_RESET, MAX_HEIGHT));
            r_x    <= '0;
            r_y    <= '0;
            r_left <= '0;
        end else begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_left <= n_left;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GRID_WIDTH:  r_w_m1 <= XW'(dim_m1(i_cfg_data, MAX_WIDTH));
                    REG_GRID_HEIGHT: r_h_m1 <= YW'(dim_m1(i_cfg_data, MAX_HEIGHT));
                    default: ;
                endcase
            end
        end
    end

    js2d_line_mem #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2 * SB),
        .AW    (XW)
    ) u_line_mem (
        .i_clk       (i_clk),
        .i_wr_en     (accept),
        .i_wr_addr   (r_x),
        .i_wr_data   ({center, i_sample}),
        .i_rd_addr_a (n_x),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    js2d_out_queue #(
        .WIDTH (WORD_BITS)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (data0),
        .i_data1 (word_own),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_data  (q_data),
        .i_stall (i_out_stall)
    );

    assign o_result       = q_data[WORD_BITS-1 -: SB];
    assign o_out_row      = q_data[2*COORD_BITS+1 -: COORD_BITS];
    assign o_out_col      = q_data[COORD_BITS+1 -: COORD_BITS];
    assign o_last_of_item = q_data[1];
    assign o_frame_done   = q_data[0];

endmodule

// ----- rtl/core/js2d_checker.sv -----
// ----------------------------------------------------------------------------
// js2d_checker
// Port-level checks on the result channel of the Jacobi stencil stream.
// ----------------------------------------------------------------------------
module js2d_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [SAMPLE_BITS-1:0]          o_result,
    input logic [js2d_pkg::COORD_BITS-1:0] o_out_row,
    input logic [js2d_pkg::COORD_BITS-1:0] o_out_col,
    input logic                            o_last_of_item,
    input logic                            o_frame_done
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result)
            && $stable(o_out_row) && $stable(o_out_col)
            && $stable(o_last_of_item) && $stable(o_frame_done))
        else $error("stalled result word changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_last_of_item)
        else $error("frame done on a word that is not last of its item");

    a_pair_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_item && !i_out_stall |=> o_out_valid)
        else $error("second word of a pair missing");

    a_pair_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_item && !i_out_stall
            |=> o_out_col == $past(o_out_col) && o_last_of_item)
        else $error("second word of a pair on another column");

endmodule

bind jacobi_stencil_2d_stream js2d_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_js2d_checker (.*);

// ----- tb/tb_jacobi_stencil_2d_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jacobi_stencil_2d_stream
// Streams grids of several sizes through the stencil block and follows each
// accepted sample with its own line-store model. Every result word is checked
// field by field against the oldest predicted cell. Both channels pause and
// stall at random, and the grid size is rewritten between runs of frames.
// ----------------------------------------------------------------------------
module tb_jacobi_stencil_2d_stream;
    import js2d_pkg::*;

    localparam int SAMPLE_W     = 16;
    localparam int MAX_W        = 2048;
    localparam int MAX_H        = 2048;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int QUIET_LIMIT  = 1000;
    localparam int EDGE_ITEMS   = 64;
    localparam int RANDOM_ITEMS = 400;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t               value;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  last;
        logic                  done;
    } cell_t;

    class sweep_tracker;
        cell_t       due_cells[$];
        sample_t     row_above[MAX_W];
        sample_t     row_above2[MAX_W];
        sample_t     left_cell;
        int unsigned width_set;
        int unsigned height_set;
        int unsigned next_col;
        int unsigned next_row;
        int          errors;

        function new();
            width_set  = DIM_RESET;
            height_set = DIM_RESET;
            errors     = 0;
            foreach (row_above[i]) begin
                row_above[i]  = '0;
                row_above2[i] = '0;
            end
            restart();
        endfunction

        function void restart();
            next_col  = 0;
            next_row  = 0;
            left_cell = '0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned top);
            if (v == 0) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
            if (idx == REG_GRID_WIDTH) begin
                width_set = d;
            end else begin
                height_set = d;
            end
            restart();
        endfunction

        function void take_sample(sample_t s);
            int unsigned       w;
            int unsigned       h;
            int unsigned       x;
            int unsigned       y;
            sample_t           center;
            sample_t           up;
            sample_t           right_cell;
            logic [SAMPLE_W+1:0] sum;
            bit                last_row;
            bit                last_col;
            cell_t             c;
            w = clamp_dim(width_set, MAX_W);
            h = clamp_dim(height_set, MAX_H);
            if (next_col >= w || next_row >= h) restart();
            x = next_col;
            y = next_row;
            last_row   = (y == h - 1);
            last_col   = (x == w - 1);
            center     = row_above[x];
            up         = row_above2[x];
            right_cell = (x + 1 < w) ? row_above[x + 1] : '0;
            sum = up + s + left_cell + right_cell;
            if (y >= 1) begin
                c.value = (y == 1 || x == 0 || last_col) ? center : sample_t'(sum >> 2);
                c.row   = COORD_BITS'(y - 1);
                c.col   = COORD_BITS'(x);
                c.last  = !last_row;
                c.done  = 1'b0;
                due_cells.push_back(c);
            end
            if (last_row) begin
                c.value = s;
                c.row   = COORD_BITS'(y);
                c.col   = COORD_BITS'(x);
                c.last  = 1'b1;
                c.done  = last_col;
                due_cells.push_back(c);
            end
            left_cell     = center;
            row_above2[x] = center;
            row_above[x]  = s;
            if (last_col) begin
                next_col  = 0;
                left_cell = '0;
                next_row  = last_row ? 0 : y + 1;
            end else begin
                next_col = x + 1;
            end
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_cell(cell_t got);
            cell_t want;
            if (due_cells.size() == 0) begin
                $display("%0t ns: word with nothing expected, actual 0x%0h row %0d col %0d",
                         $time, got.value, got.row, got.col);
                errors++;
                return;
            end
            want = due_cells.pop_front();
            compare("result", want.value, got.value);
            compare("out_row", want.row, got.row);
            compare("out_col", want.col, got.col);
            compare("last_of_item", want.last, got.last);
            compare("frame_done", want.done, got.done);
        endfunction
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = REG_GRID_WIDTH;
    logic [CFG_BITS-1:0]       i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    sample_t                   i_sample    = '0;
    logic                      i_out_stall = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    sample_t                   o_result;
    logic [COORD_BITS-1:0]     o_out_row;
    logic [COORD_BITS-1:0]     o_out_col;
    logic                      o_last_of_item;
    logic                      o_frame_done;

    sweep_tracker tracker;
    int           in_gap_max  = 0;
    int           out_gap_max = 0;
    int           out_hold    = 0;

    jacobi_stencil_2d_stream #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .SAMPLE_BITS(SAMPLE_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (o_result),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_of_item(o_last_of_item),
        .o_frame_done  (o_frame_done)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_hold = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                tracker.check_cell({o_result, o_out_row, o_out_col, o_last_of_item,
                                    o_frame_done});
                out_hold = $urandom_range(0, out_gap_max);
            end else if (out_hold > 0) begin
                out_hold = out_hold - 1;
            end
            i_out_stall <= (out_hold != 0);
        end
    end

    function automatic int pick_gap_max();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 6;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic int unsigned pick_dim(int unsigned top);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 3;
            default: return $urandom_range(1, top);
        endcase
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return sample_t'($urandom_range(0, (1 << SAMPLE_W) - 1));
        endcase
    endfunction

    task automatic send_sample(sample_t s);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_sample(s);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.due_cells.size() != 0);
    endtask

    task automatic program_reg(logic [CFG_INDEX_BITS-1:0] idx, int unsigned d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_BITS'(d);
        @(posedge i_clk);
        tracker.set_reg(idx, CFG_BITS'(d));
    endtask

    task automatic set_grid(int unsigned w, int unsigned h);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if ($urandom_range(0, 1)) begin
            program_reg(REG_GRID_WIDTH, w);
            program_reg(REG_GRID_HEIGHT, h);
        end else begin
            program_reg(REG_GRID_HEIGHT, h);
            program_reg(REG_GRID_WIDTH, w);
        end
        i_cfg_we    <= 1'b0;
        in_gap_max  = pick_gap_max();
        out_gap_max = pick_gap_max();
    endtask

    initial begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned cells;
        int unsigned n;
        int unsigned sent;
        bit          paused;
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_gap_max  = 6;
        out_gap_max = 6;

        // first row of the reset-size grid emits nothing
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);

        // full-scale neighbors around the center cell
        set_grid(3, 3);
        for (int i = 0; i < 9; i++) send_sample((i % 2) ? '1 : '0);

        set_grid(0, 0);
        send_sample(16'h1234);
        send_sample(16'hEDCB);

        set_grid(2, 3);
        for (int i = 0; i < 6; i++) send_sample(rand_sample());

        set_grid((1 << CFG_BITS) - 1, 1);
        for (int i = 0; i < EDGE_ITEMS; i++) send_sample(rand_sample());

        set_grid(1, (1 << CFG_BITS) - 1);
        for (int i = 0; i < EDGE_ITEMS; i++) send_sample(rand_sample());

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            w = pick_dim(32);
            h = pick_dim(8);
            set_grid(w, h);
            cells = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            n = cells * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n = n - $urandom_range(0, cells - 1);
            if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
            for (int i = 0; i < n; i++) begin
                if ((!paused && i == n / 2) || $urandom_range(0, 99) == 0) begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_sample(rand_sample());
            end
            sent += n;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/js2d_pkg.sv
rtl/core/js2d_line_mem.sv
rtl/core/js2d_out_queue.sv
rtl/core/jacobi_stencil_2d_stream.sv
rtl/core/js2d_checker.sv
tb/tb_jacobi_stencil_2d_stream.sv
